/* src/mtse_pkg.sv */
// ----------------------------------------------------------------------------
// mtse_pkg
// Shared types and constants for the millisecond timer slot engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mtse_pkg;

  // Fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TASK_W  = 8;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned DAYC_W  = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // Time constants in milliseconds
  localparam logic [TIME_W-1:0] DAY_MS  = 32'd86400000;
  localparam logic [TIME_W-1:0] WEEK_MS = 32'd604800000;
  localparam logic [DAYC_W-1:0] DAYC_MAX = 8'hFF;

  // Configuration register indexes
  localparam logic [1:0] REG_TICK_WHOLE = 2'd0;
  localparam logic [1:0] REG_TICK_FRAC  = 2'd1;
  localparam logic [1:0] REG_FRAC_PER   = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] TICK_WHOLE_RST = 8'd16;
  localparam logic [CFG_W-1:0] TICK_FRAC_RST  = 8'd48;
  localparam logic [CFG_W-1:0] FRAC_PER_RST   = 8'd125;

  // Input operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_ARM_REL = 2'd1,
    OP_ARM_ABS = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    RES_IDLE    = 3'd0,
    RES_EXPIRED = 3'd1,
    RES_ARMED   = 3'd2,
    RES_DUE     = 3'd3,
    RES_NO_SLOT = 3'd4,
    RES_RANGE   = 3'd5
  } res_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_SCAN,
    S_FIN,
    S_EMIT,
    S_ARM
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic advance;
    logic scan;
    logic finish;
    logic emit;
    logic arm;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last;
    logic emit_final;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* src/mtse_regs.sv */
// ----------------------------------------------------------------------------
// mtse_regs
// APB-style configuration registers for tick step and fraction carry.
// ----------------------------------------------------------------------------
`default_nettype none

module mtse_regs
  import mtse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [CFG_W-1:0]  tick_whole_o,
  output logic      [CFG_W-1:0]  tick_frac_o,
  output logic      [CFG_W-1:0]  frac_per_o
);

  logic [CFG_W-1:0] tick_whole_q;
  logic [CFG_W-1:0] tick_frac_q;
  logic [CFG_W-1:0] frac_per_q;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_whole_q <= TICK_WHOLE_RST;
      tick_frac_q  <= TICK_FRAC_RST;
      frac_per_q   <= FRAC_PER_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TICK_WHOLE: tick_whole_q <= pwdata[CFG_W-1:0];
        REG_TICK_FRAC:  tick_frac_q  <= pwdata[CFG_W-1:0];
        REG_FRAC_PER:   frac_per_q   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TICK_WHOLE: prdata = {{(DATA_W-CFG_W){1'b0}}, tick_whole_q};
      REG_TICK_FRAC:  prdata = {{(DATA_W-CFG_W){1'b0}}, tick_frac_q};
      REG_FRAC_PER:   prdata = {{(DATA_W-CFG_W){1'b0}}, frac_per_q};
      default:        prdata = '0;
    endcase
  end

  assign tick_whole_o = tick_whole_q;
  assign tick_frac_o  = tick_frac_q;
  assign frac_per_o   = frac_per_q;

endmodule

`default_nettype wire

/* src/mtse_ctrl.sv */
// ----------------------------------------------------------------------------
// mtse_ctrl
// Sequencer: accept, advance clock, scan slots, rebase, emit beats, arm.
// ----------------------------------------------------------------------------
`default_nettype none

module mtse_ctrl
  import mtse_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [OP_W-1:0] in_operation_i,
  input  wire dp_status_t      status_i,
  output logic                 in_stall_o,
  output ctrl_cmd_t            cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_operation_i) inside
            OP_TICK:                state_d = S_ADV;
            OP_ARM_REL, OP_ARM_ABS: state_d = S_ARM;
            default:                state_d = S_IDLE;
          endcase
        end
      end
      S_ADV:  state_d = S_SCAN;
      S_SCAN: if (status_i.scan_last) state_d = S_FIN;
      S_FIN:  state_d = S_EMIT;
      S_EMIT: if (status_i.out_free && status_i.emit_final) state_d = S_IDLE;
      S_ARM:  if (status_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_ADV:  cmd_o.advance = 1'b1;
      S_SCAN: cmd_o.scan    = 1'b1;
      S_FIN:  cmd_o.finish  = 1'b1;
      S_EMIT: cmd_o.emit    = status_i.out_free;
      S_ARM:  cmd_o.arm     = status_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* src/mtse_dp.sv */
// ----------------------------------------------------------------------------
// mtse_dp
// Datapath: clock and fraction, slot store, expiry mask, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtse_dp
  import mtse_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_status_t             status_o,
  input  wire logic [OP_W-1:0]   in_operation_i,
  input  wire logic [TIME_W-1:0] in_time_value_i,
  input  wire logic [TASK_W-1:0] in_task_id_i,
  input  wire logic [CFG_W-1:0]  tick_whole_i,
  input  wire logic [CFG_W-1:0]  tick_frac_i,
  input  wire logic [CFG_W-1:0]  frac_per_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output logic      [STAT_W-1:0] out_status_o,
  output logic      [TASK_W-1:0] out_task_id_res_o,
  output logic      [SLOT_W-1:0] out_slot_o,
  output logic      [TIME_W-1:0] out_now_ms_o,
  output logic      [DAYC_W-1:0] out_day_count_o,
  output logic                   out_last_o
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Clock state
  logic [TIME_W-1:0] now_q;
  logic [CFG_W-1:0]  frac_q;
  logic [DAYC_W-1:0] day_q;
  logic              rebase_q;

  // Slot store
  logic [NUM_SLOTS-1:0] used_q;
  logic [TIME_W-1:0]    dl_q   [NUM_SLOTS];
  logic [TASK_W-1:0]    task_q [NUM_SLOTS];

  // Scan / emit bookkeeping
  logic [IDX_W-1:0]     idx_q;
  logic [NUM_SLOTS-1:0] mask_q;

  // Captured item
  logic              rel_q;
  logic [TIME_W-1:0] tv_q;
  logic [TASK_W-1:0] tin_q;

  // Result register
  logic              out_valid_q;
  logic [STAT_W-1:0] res_stat_q;
  logic [TASK_W-1:0] res_task_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [TIME_W-1:0] res_now_q;
  logic [DAYC_W-1:0] res_day_q;
  logic              res_last_q;

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Clock advance with fraction carry
  logic [CFG_W:0]    frac_sum;
  logic              frac_carry;
  logic [CFG_W:0]    frac_rem;
  logic [TIME_W-1:0] now_adv;

  always_comb begin
    frac_sum   = {1'b0, frac_q} + {1'b0, tick_frac_i};
    frac_carry = frac_sum >= {1'b0, frac_per_i};
    frac_rem   = frac_carry ? (frac_sum - {1'b0, frac_per_i}) : frac_sum;
    now_adv    = now_q + {{(TIME_W-CFG_W){1'b0}}, tick_whole_i}
                       + {{(TIME_W-1){1'b0}}, frac_carry};
  end

  // Scan compare at the current slot
  logic scan_hit;
  assign scan_hit = used_q[idx_q] && (dl_q[idx_q] <= now_q);

  // Lowest pending expiry
  logic [IDX_W-1:0] emit_idx;
  logic [NUM_SLOTS-1:0] mask_rest;

  always_comb begin
    emit_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_q[i]) emit_idx = IDX_W'(i);
    end
    mask_rest = mask_q & (mask_q - NUM_SLOTS'(1));
  end

  // Lowest free slot for arm
  logic [IDX_W-1:0] free_idx;
  logic             any_free;

  always_comb begin
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) free_idx = IDX_W'(i);
    end
    any_free = !(&used_q);
  end

  // Arm checks
  logic [TIME_W:0] now_ext;
  logic [TIME_W:0] wake;
  logic            arm_range;
  logic            arm_due;

  always_comb begin
    now_ext   = {1'b0, now_q};
    wake      = rel_q ? (now_ext + {1'b0, tv_q}) : {1'b0, tv_q};
    arm_range = rel_q ? (tv_q >= DAY_MS) : ({1'b0, tv_q} >= (now_ext + {1'b0, DAY_MS}));
    arm_due   = wake <= now_ext;
  end

  // Slot index onto the result field width
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] tmp;
    tmp = {{SLOT_W{1'b0}}, idx};
    return tmp[SLOT_W-1:0];
  endfunction

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q    <= '0;
      frac_q   <= '0;
      day_q    <= '0;
      rebase_q <= 1'b0;
      used_q   <= '0;
      idx_q    <= '0;
      mask_q   <= '0;
    end else begin
      if (cmd_i.advance) begin
        now_q    <= now_adv;
        frac_q   <= frac_rem[CFG_W-1:0];
        rebase_q <= now_adv >= WEEK_MS;
        idx_q    <= '0;
        mask_q   <= '0;
      end
      if (cmd_i.scan) begin
        if (scan_hit) begin
          mask_q[idx_q] <= 1'b1;
          used_q[idx_q] <= 1'b0;
        end
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.finish && rebase_q) begin
        now_q <= now_q - DAY_MS;
        if (day_q != DAYC_MAX) day_q <= day_q + DAYC_W'(1);
      end
      if (cmd_i.emit) begin
        mask_q <= mask_rest;
      end
      if (cmd_i.arm && !arm_range && !arm_due && any_free) begin
        used_q[free_idx] <= 1'b1;
      end
    end
  end

  // Slot payload and captured item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rel_q <= in_operation_i == OP_ARM_REL;
      tv_q  <= in_time_value_i;
      tin_q <= in_task_id_i;
    end
    if (cmd_i.scan && used_q[idx_q] && !scan_hit && rebase_q) begin
      dl_q[idx_q] <= dl_q[idx_q] - DAY_MS;
    end
    if (cmd_i.arm && !arm_range && !arm_due && any_free) begin
      dl_q[free_idx]   <= wake[TIME_W-1:0];
      task_q[free_idx] <= tin_q;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.arm) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_now_q  <= now_q;
      res_day_q  <= day_q;
      res_last_q <= mask_rest == '0;
      if (mask_q == '0) begin
        res_stat_q <= RES_IDLE;
        res_task_q <= '0;
        res_slot_q <= '0;
      end else begin
        res_stat_q <= RES_EXPIRED;
        res_task_q <= task_q[emit_idx];
        res_slot_q <= to_slot(emit_idx);
      end
    end else if (cmd_i.arm) begin
      res_now_q  <= now_q;
      res_day_q  <= day_q;
      res_last_q <= 1'b1;
      res_task_q <= tin_q;
      res_slot_q <= '0;
      if (arm_range) begin
        res_stat_q <= RES_RANGE;
      end else if (arm_due) begin
        res_stat_q <= RES_DUE;
      end else if (!any_free) begin
        res_stat_q <= RES_NO_SLOT;
      end else begin
        res_stat_q <= RES_ARMED;
        res_slot_q <= to_slot(free_idx);
      end
    end
  end

  // Status to controller
  assign status_o.scan_last  = idx_q == IDX_W'(NUM_SLOTS - 1);
  assign status_o.emit_final = mask_rest == '0;
  assign status_o.out_free   = out_free;

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = res_stat_q;
  assign out_task_id_res_o = res_task_q;
  assign out_slot_o        = res_slot_q;
  assign out_now_ms_o      = res_now_q;
  assign out_day_count_o   = res_day_q;
  assign out_last_o        = res_last_q;

endmodule

`default_nettype wire

/* src/millisecond_timer_slot_engine.sv */
// ----------------------------------------------------------------------------
// millisecond_timer_slot_engine
// Millisecond clock with day rebase and one-shot wakeup slots.
// ----------------------------------------------------------------------------
// Tick: after accept, advance the clock, compare one slot per cycle, rebase;
//   then one beat per cycle per expiry while the output is free.
// Arm: the result beat is registered once the output is free; the next item
//   is taken after that, back in idle.
// One item in flight at a time; the next is taken once its last beat loads.
// Reset clears clock, fraction, day count and slot use; config takes defaults.
`default_nettype none

module millisecond_timer_slot_engine
  import mtse_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [OP_W-1:0]   in_operation_i,
  input  wire logic [TIME_W-1:0] in_time_value_i,
  input  wire logic [TASK_W-1:0] in_task_id_i,
  // Output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [STAT_W-1:0] out_status_o,
  output logic      [TASK_W-1:0] out_task_id_res_o,
  output logic      [SLOT_W-1:0] out_slot_o,
  output logic      [TIME_W-1:0] out_now_ms_o,
  output logic      [DAYC_W-1:0] out_day_count_o,
  output logic                   out_last_o,
  // Configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic [CFG_W-1:0] tick_whole;
  logic [CFG_W-1:0] tick_frac;
  logic [CFG_W-1:0] frac_per;
  ctrl_cmd_t        cmd;
  dp_status_t       dp_status;

  // Configuration registers
  mtse_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .tick_whole_o (tick_whole),
    .tick_frac_o  (tick_frac),
    .frac_per_o   (frac_per)
  );

  // Sequencer
  mtse_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_operation_i (in_operation_i),
    .status_i       (dp_status),
    .in_stall_o     (in_stall_o),
    .cmd_o          (cmd)
  );

  // Datapath
  mtse_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (dp_status),
    .in_operation_i    (in_operation_i),
    .in_time_value_i   (in_time_value_i),
    .in_task_id_i      (in_task_id_i),
    .tick_whole_i      (tick_whole),
    .tick_frac_i       (tick_frac),
    .frac_per_i        (frac_per),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .out_status_o      (out_status_o),
    .out_task_id_res_o (out_task_id_res_o),
    .out_slot_o        (out_slot_o),
    .out_now_ms_o      (out_now_ms_o),
    .out_day_count_o   (out_day_count_o),
    .out_last_o        (out_last_o)
  );

endmodule

`default_nettype wire

/* dv/tb_millisecond_timer_slot_engine.sv */
// ----------------------------------------------------------------------------
// tb_millisecond_timer_slot_engine
// Self-checking bench for the millisecond timer slot engine. A shadow copy of
// the clock, fraction, day count and wakeup slots predicts every result beat;
// the monitor compares each beat field by field in order. A directed pass
// covers arm range limits, due times, full slots and multi-slot expiry; then
// random traffic runs under several tick settings and handshake idle mixes.
// ----------------------------------------------------------------------------

module tb_millisecond_timer_slot_engine;
  import mtse_pkg::*;

  localparam int SLOTS        = 4;
  localparam int DRAIN_CYCLES = 4 * (SLOTS + 4);
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_TIME   = 4_000_000;

  // operation code the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one result beat as seen on the output channel
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TASK_W-1:0] tid;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now_ms;
    logic [DAYC_W-1:0] days;
    logic              last;
  } wake_beat_t;

  // Shadow of the timer state; owes result beats for accepted items
  class wakeup_ledger;
    logic [CFG_W-1:0]  whole_ms;
    logic [CFG_W-1:0]  frac_step;
    logic [CFG_W-1:0]  frac_per_ms;
    logic [TIME_W-1:0] clock_ms;
    logic [CFG_W-1:0]  frac_acc;
    logic [DAYC_W-1:0] days;
    logic              used[SLOTS];
    logic [TIME_W-1:0] deadline[SLOTS];
    logic [TASK_W-1:0] owner[SLOTS];
    wake_beat_t        owed_beats[$];
    int                miscompares;

    function new();
      whole_ms    = TICK_WHOLE_RST;
      frac_step   = TICK_FRAC_RST;
      frac_per_ms = FRAC_PER_RST;
      clock_ms    = '0;
      frac_acc    = '0;
      days        = '0;
      miscompares = 0;
      for (int i = 0; i < SLOTS; i++) begin
        used[i]     = 1'b0;
        deadline[i] = '0;
        owner[i]    = '0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_TICK_WHOLE: whole_ms    = value;
        REG_TICK_FRAC:  frac_step   = value;
        REG_FRAC_PER:   frac_per_ms = value;
        default: ;
      endcase
    endfunction

    function void owe(logic [STAT_W-1:0] status, logic [TASK_W-1:0] tid,
                      logic [SLOT_W-1:0] slot, logic last);
      wake_beat_t b;
      b.status = status;
      b.tid    = tid;
      b.slot   = slot;
      b.now_ms = clock_ms;
      b.days   = days;
      b.last   = last;
      owed_beats.push_back(b);
    endfunction

    // advance clock, expire due slots in order, rebase past a week
    function void tick();
      int unsigned       sum;
      logic              rebase;
      int                n;
      logic [TASK_W-1:0] hit_tid[SLOTS];
      logic [SLOT_W-1:0] hit_slot[SLOTS];
      n = 0;
      clock_ms = clock_ms + whole_ms;
      sum = 32'(frac_acc) + 32'(frac_step);
      if (sum >= frac_per_ms) begin
        sum = sum - frac_per_ms;
        clock_ms = clock_ms + 1;
      end
      frac_acc = sum[CFG_W-1:0];
      rebase = (clock_ms >= WEEK_MS);
      for (int i = 0; i < SLOTS; i++) begin
        if (used[i]) begin
          if (deadline[i] <= clock_ms) begin
            used[i]     = 1'b0;
            hit_tid[n]  = owner[i];
            hit_slot[n] = i[SLOT_W-1:0];
            n++;
          end else if (rebase) begin
            deadline[i] = deadline[i] - DAY_MS;
          end
        end
      end
      if (rebase) begin
        clock_ms = clock_ms - DAY_MS;
        if (days != DAYC_MAX) days = days + DAYC_W'(1);
      end
      if (n == 0) owe(RES_IDLE, '0, '0, 1'b1);
      for (int i = 0; i < n; i++) owe(RES_EXPIRED, hit_tid[i], hit_slot[i], i == n - 1);
    endfunction

    // range check first, then due, then lowest free slot
    function void arm(logic relative, logic [TIME_W-1:0] tv, logic [TASK_W-1:0] tid);
      logic [TIME_W:0] wake;
      logic [TIME_W:0] now_wide;
      logic            too_far;
      now_wide = {1'b0, clock_ms};
      if (relative) begin
        wake    = now_wide + {1'b0, tv};
        too_far = (tv >= DAY_MS);
      end else begin
        wake    = {1'b0, tv};
        too_far = (wake >= now_wide + {1'b0, DAY_MS});
      end
      if (too_far) begin
        owe(RES_RANGE, tid, '0, 1'b1);
        return;
      end
      if (wake <= now_wide) begin
        owe(RES_DUE, tid, '0, 1'b1);
        return;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (!used[i]) begin
          used[i]     = 1'b1;
          deadline[i] = wake[TIME_W-1:0];
          owner[i]    = tid;
          owe(RES_ARMED, tid, i[SLOT_W-1:0], 1'b1);
          return;
        end
      end
      owe(RES_NO_SLOT, tid, '0, 1'b1);
    endfunction

    function void post_item(logic [OP_W-1:0] op, logic [TIME_W-1:0] tv,
                            logic [TASK_W-1:0] tid);
      case (op)
        OP_TICK:    tick();
        OP_ARM_REL: arm(1'b1, tv, tid);
        OP_ARM_ABS: arm(1'b0, tv, tid);
        default: ;
      endcase
    endfunction

    function void match_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        miscompares++;
      end
    endfunction

    function void match_beat(wake_beat_t got);
      wake_beat_t want;
      if (owed_beats.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d task %0d slot %0d",
               got.status, got.tid, got.slot);
        miscompares++;
        return;
      end
      want = owed_beats.pop_front();
      match_field("status",      want.status, got.status);
      match_field("task_id_res", want.tid,    got.tid);
      match_field("slot",        want.slot,   got.slot);
      match_field("now_ms",      want.now_ms, got.now_ms);
      match_field("day_count",   want.days,   got.days);
      match_field("last",        want.last,   got.last);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   in_operation_i;
  logic [TIME_W-1:0] in_time_value_i;
  logic [TASK_W-1:0] in_task_id_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [STAT_W-1:0] out_status_o;
  logic [TASK_W-1:0] out_task_id_res_o;
  logic [SLOT_W-1:0] out_slot_o;
  logic [TIME_W-1:0] out_now_ms_o;
  logic [DAYC_W-1:0] out_day_count_o;
  logic              out_last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  wakeup_ledger ledger;
  int           send_idle_pct = 0;
  int           stall_pct     = 0;
  logic         hold_active   = 1'b0;
  event         hold_ev;

  millisecond_timer_slot_engine #(
    .NUM_SLOTS(SLOTS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_operation_i   (in_operation_i),
    .in_time_value_i  (in_time_value_i),
    .in_task_id_i     (in_task_id_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_status_o     (out_status_o),
    .out_task_id_res_o(out_task_id_res_o),
    .out_slot_o       (out_slot_o),
    .out_now_ms_o     (out_now_ms_o),
    .out_day_count_o  (out_day_count_o),
    .out_last_o       (out_last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 4-unit clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // receiver stall: random, or forced high during a hold-off
  always @(negedge clk_i) begin
    out_stall_i = hold_active || ($urandom_range(0, 99) < stall_pct);
  end

  // long receiver hold-off, counted here so the sender keeps pushing
  always begin
    @(hold_ev);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
  end

  // output monitor
  always @(posedge clk_i) begin
    wake_beat_t got;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got.status = out_status_o;
      got.tid    = out_task_id_res_o;
      got.slot   = out_slot_o;
      got.now_ms = out_now_ms_o;
      got.days   = out_day_count_o;
      got.last   = out_last_o;
      ledger.match_beat(got);
    end
  end

  // one input beat, with optional sender gaps first
  task automatic send_item(logic [OP_W-1:0] op, logic [TIME_W-1:0] tv, logic [TASK_W-1:0] tid);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      = 1'b1;
    in_operation_i  = op;
    in_time_value_i = tv;
    in_task_id_i    = tid;
    do @(posedge clk_i); while (in_stall_o);
    ledger.post_item(op, tv, tid);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {{(DATA_W-CFG_W){1'b0}}, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    ledger.set_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(logic [CFG_W-1:0] whole, logic [CFG_W-1:0] frac,
                           logic [CFG_W-1:0] per);
    write_reg(REG_TICK_WHOLE, whole);
    write_reg(REG_TICK_FRAC, frac);
    write_reg(REG_FRAC_PER, per);
  endtask

  // drop valid, drain every owed beat, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (ledger.owed_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // random item: deadlines mostly a few ticks out so slots really expire
  task automatic pick_item(output logic [OP_W-1:0] op, output logic [TIME_W-1:0] tv,
                           output logic [TASK_W-1:0] tid);
    int          r;
    int          sub;
    int unsigned span;
    span = (ledger.whole_ms + 2) * 6;
    r    = $urandom_range(0, 99);
    sub  = $urandom_range(0, 9);
    tid  = TASK_W'($urandom_range(0, 255));
    tv   = '0;
    if (r < 8) begin
      op = OP_UNUSED;
      tv = $urandom;
    end else if (r < 50) begin
      op = OP_TICK;
      tv = $urandom;
    end else if (r < 78) begin
      op = OP_ARM_REL;
      case (sub)
        0:       tv = '0;
        1:       tv = $urandom;
        2:       tv = DAY_MS - $urandom_range(0, 1);
        default: tv = $urandom_range(1, span);
      endcase
    end else begin
      op = OP_ARM_ABS;
      case (sub)
        0:       tv = $urandom;
        1:       tv = ledger.clock_ms - $urandom_range(0, span);
        2:       tv = ledger.clock_ms + DAY_MS - $urandom_range(0, 1);
        default: tv = ledger.clock_ms + $urandom_range(1, span);
      endcase
    end
  endtask

  // random traffic; ignored operations do not count toward n_items
  task automatic run_random(int n_items, int hold_at);
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] tv;
    logic [TASK_W-1:0] tid;
    int                sent;
    sent = 0;
    while (sent < n_items) begin
      if (sent == hold_at) -> hold_ev;
      pick_item(op, tv, tid);
      send_item(op, tv, tid);
      if (op != OP_UNUSED) sent++;
    end
  endtask

  task automatic run_directed();
    send_item(OP_TICK, 32'h0, 8'h00);                  // idle tick
    send_item(OP_ARM_REL, 32'h0, 8'h00);               // zero wait is already due
    send_item(OP_ARM_REL, DAY_MS, 8'hFF);              // a full day is out of range
    send_item(OP_ARM_REL, DAY_MS - 1, 8'hA5);          // farthest relative, slot 0
    send_item(OP_ARM_ABS, ledger.clock_ms + DAY_MS, 8'h11);
    send_item(OP_ARM_ABS, 32'hFFFF_FFFF, 8'h22);
    send_item(OP_ARM_ABS, ledger.clock_ms, 8'h33);     // exactly now is due
    send_item(OP_ARM_ABS, 32'h0, 8'h44);
    send_item(OP_ARM_REL, 32'd1, 8'h01);
    send_item(OP_ARM_ABS, ledger.clock_ms + 2, 8'h02);
    send_item(OP_ARM_REL, 32'd3, 8'h03);
    send_item(OP_ARM_REL, 32'd5, 8'h04);               // all slots taken
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);        // ignored, no beat
    send_item(OP_TICK, 32'hFFFF_FFFF, 8'hFF);          // three expiries in one tick
    send_item(OP_TICK, 32'h0, 8'h00);
    send_item(OP_ARM_ABS, ledger.clock_ms + DAY_MS - 1, 8'h5A);
    send_item(OP_ARM_REL, 32'd2, 8'h06);
    send_item(OP_ARM_REL, 32'd3, 8'h07);
    send_item(OP_TICK, 32'h0, 8'h00);                  // two expiries
    send_item(OP_TICK, 32'h0, 8'h00);
  endtask

  initial begin
    ledger          = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_operation_i  = OP_TICK;
    in_time_value_i = '0;
    in_task_id_i    = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();

    // widest tick, no idling
    settle();
    configure(8'd255, 8'd254, 8'd255);
    run_random(70, -1);

    // 1 ms per tick via carry every tick, sparse sender
    settle();
    configure(8'd0, 8'd1, 8'd1);
    send_idle_pct = 76;
    stall_pct     = 0;
    run_random(65, -1);

    // slow clock, busy receiver with one long hold-off
    settle();
    configure(8'd3, 8'd0, 8'd255);
    send_idle_pct = 0;
    stall_pct     = 76;
    run_random(70, 20);

    // both sides idle now and then
    settle();
    configure(8'd40, 8'd77, 8'd100);
    send_idle_pct = 20;
    stall_pct     = 20;
    run_random(65, -1);

    settle();
    if (ledger.miscompares == 0 && ledger.owed_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_TIME);
    $display("TEST FAILED");
    $finish;
  end

endmodule
